/* src/pcfm_pkg.sv */
// ----------------------------------------------------------------------------
// pcfm_pkg
// Shared types and constants for the period capture frequency meter.
// ----------------------------------------------------------------------------
package pcfm_pkg;

  localparam int STAMP_W    = 64;
  localparam int WINDOW_W   = 32;
  localparam int NUMER_W    = 24;
  localparam int FREQ_W     = 32;
  localparam int FRAC_W     = 8;
  localparam int CFG_DATA_W = 32;
  localparam int DVD_W      = NUMER_W + FRAC_W;
  localparam int CNT_W      = $clog2(DVD_W);

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000000;
  localparam logic [NUMER_W-1:0]  NUMER_RESET  = 24'd125000;

  typedef enum logic [0:0] {
    REG_TIMEOUT_WINDOW = 1'b0,
    REG_RATE_NUMERATOR = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    MODE_CAPTURE = 1'b0,
    MODE_QUERY   = 1'b1
  } mode_t;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [STAMP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* src/pcfm_stamp_store.sv */
// ----------------------------------------------------------------------------
// pcfm_stamp_store
// Per-channel latest and previous capture timestamps.
// ----------------------------------------------------------------------------
module pcfm_stamp_store
  import pcfm_pkg::*;
#(
  parameter int NUM_CHANNELS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cap_en,
  input  logic               cap_channel,
  input  logic [STAMP_W-1:0] cap_stamp,
  input  logic               rd_channel,
  output logic [STAMP_W-1:0] rd_latest,
  output logic [STAMP_W-1:0] rd_previous
);

  logic [STAMP_W-1:0] latest_r   [NUM_CHANNELS];
  logic [STAMP_W-1:0] previous_r [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        latest_r[i]   <= '0;
        previous_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (cap_en && (32'(cap_channel) == i)) begin
          previous_r[i] <= latest_r[i];
          latest_r[i]   <= cap_stamp;
        end
      end
    end
  end

  always_comb begin
    rd_latest   = '0;
    rd_previous = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (32'(rd_channel) == i) begin
        rd_latest   = latest_r[i];
        rd_previous = previous_r[i];
      end
    end
  end

endmodule

/* src/pcfm_divider.sv */
// ----------------------------------------------------------------------------
// pcfm_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcfm_divider
  import pcfm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [STAMP_W-1:0] rem_r, rem_nxt;
  logic [STAMP_W-1:0] dsr_r, dsr_nxt;
  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [STAMP_W:0]   trial;
  logic [STAMP_W:0]   diff;
  logic               q_bit;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign q_bit = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      dvd_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = q_bit ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], q_bit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

/* src/period_capture_freq_meter.sv */
// ----------------------------------------------------------------------------
// period_capture_freq_meter
// Timestamp based frequency meter: captures store stamps, queries return
// rate_numerator * 256 / period in unsigned Q.8.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_mode, in_channel, in_now_ticks
//   out      output     out_valid/out_stall out_freq_q8, out_stale, out_div_zero
//   cfg      input      cfg_we              cfg_index, cfg_wdata
//
// a capture transfer gives no result
// a query steps through prep, check, the 32-step bit-serial divider and emit
// before the next transfer; stale and zero-period queries skip the divider
// one item at a time: in_stall is high from a query transfer until its result
// is loaded into the output register
// out_stall holds the result; reset clears stamps and loads register defaults
// ----------------------------------------------------------------------------
module period_capture_freq_meter
  import pcfm_pkg::*;
#(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic                  in_channel,
  input  logic [STAMP_W-1:0]    in_now_ticks,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FREQ_W-1:0]     out_freq_q8,
  output logic                  out_stale,
  output logic                  out_div_zero
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [WINDOW_W-1:0] window_r;
  logic [NUMER_W-1:0]  numer_r;
  logic                ch_r;
  logic                ch_ok_r;
  logic [STAMP_W-1:0]  thresh_r;
  logic                stale_r, stale_nxt;
  logic [STAMP_W-1:0]  period_r, period_nxt;
  logic [FREQ_W-1:0]   res_freq_r, res_freq_nxt;
  logic                res_stale_r, res_stale_nxt;
  logic                res_dz_r, res_dz_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [FREQ_W-1:0]   out_freq_r;
  logic                out_stale_r, out_dz_r;
  logic                in_xfer, cap_en, load_out;
  logic [STAMP_W-1:0]  rd_latest, rd_previous;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cap_en   = in_xfer && (in_mode == MODE_CAPTURE);
  assign load_out = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  pcfm_stamp_store #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap_en     (cap_en),
    .cap_channel(in_channel),
    .cap_stamp  (in_now_ticks),
    .rd_channel (ch_r),
    .rd_latest  (rd_latest),
    .rd_previous(rd_previous)
  );

  pcfm_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      numer_r  <= NUMER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMEOUT_WINDOW: window_r <= cfg_wdata[WINDOW_W-1:0];
        REG_RATE_NUMERATOR: numer_r  <= cfg_wdata[NUMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt        = state_r;
    stale_nxt        = stale_r;
    period_nxt       = period_r;
    res_freq_nxt     = res_freq_r;
    res_stale_nxt    = res_stale_r;
    res_dz_nxt       = res_dz_r;
    div_req.start    = 1'b0;
    div_req.dividend = {numer_r, {FRAC_W{1'b0}}};
    div_req.divisor  = period_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_mode == MODE_QUERY)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        stale_nxt  = !(ch_ok_r && (rd_latest > thresh_r));
        period_nxt = rd_latest - rd_previous;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        if (stale_r) begin
          res_freq_nxt  = '0;
          res_stale_nxt = 1'b1;
          res_dz_nxt    = 1'b0;
          state_nxt     = ST_EMIT;
        end else if (period_r == '0) begin
          res_freq_nxt  = '0;
          res_stale_nxt = 1'b0;
          res_dz_nxt    = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_freq_nxt  = div_rsp.quotient;
          res_stale_nxt = 1'b0;
          res_dz_nxt    = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch_r     <= in_channel;
      ch_ok_r  <= (32'(in_channel) < NUM_CHANNELS);
      thresh_r <= in_now_ticks - {{(STAMP_W-WINDOW_W){1'b0}}, window_r};
    end
    stale_r     <= stale_nxt;
    period_r    <= period_nxt;
    res_freq_r  <= res_freq_nxt;
    res_stale_r <= res_stale_nxt;
    res_dz_r    <= res_dz_nxt;
    if (load_out) begin
      out_freq_r  <= res_freq_r;
      out_stale_r <= res_stale_r;
      out_dz_r    <= res_dz_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_freq_q8  = out_freq_r;
  assign out_stale    = out_stale_r;
  assign out_div_zero = out_dz_r;

  // checks
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_mode == MODE_QUERY)) |=> (state_r == ST_PREP))
    else $error("query transfer did not start the sequencer");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_stale && out_div_zero))
    else $error("stale and div_zero both set");

  a_flag_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_stale || out_div_zero)) |-> (out_freq_q8 == '0))
    else $error("flagged result with nonzero frequency");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide state");

endmodule
